>>> design/pfe_pkg.sv
// Package for the streaming Playfair encryptor: letter codes, ASCII constants,
// key square types and the square lookup functions.
// Depends on nothing; every other file of the block uses it.
package pfe_pkg;

  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 5;
  localparam int ASCII_W  = 7;
  localparam int DIM      = 5;
  localparam int ROW_W    = DIM * CODE_W;
  localparam int POS_W    = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [DIM-1:0][CODE_W-1:0] row_t;
  typedef logic [DIM-1:0][DIM-1:0][CODE_W-1:0] square_t;

  localparam code_t CODE_I = 5'd8;
  localparam code_t CODE_J = 5'd9;
  localparam code_t CODE_X = 5'd23;
  localparam code_t CODE_Z = 5'd25;

  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [ASCII_W-1:0] ASCII_BASE   = 7'h41;

  localparam pos_t POS_LAST = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW4 = 3'd4;

  // Reset square ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ, row 0 lowest.
  localparam square_t SQUARE_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                      25'd10755269, 25'd4294688};

  typedef struct packed {
    code_t first;
    code_t second;
  } pair_t;

  // One pair of letters on its way to the cipher, with its item flags.
  typedef struct packed {
    pair_t pair;
    logic  last;
    logic  msg_end;
  } pair_req_t;

  // The two cipher codes of one pair, with the same flags.
  typedef struct packed {
    code_t first;
    code_t second;
    logic  last;
    logic  msg_end;
  } coded_pair_t;

  typedef struct packed {
    pos_t row;
    pos_t col;
  } cell_pos_t;

  function automatic pos_t pos_inc(input pos_t p);
    return (p == POS_LAST) ? '0 : pos_t'(p + 3'd1);
  endfunction

  // Position of a code in the square. The last match in row-major order
  // wins, and a code that is absent maps to the top left cell.
  function automatic cell_pos_t locate(input square_t sq, input code_t code);
    cell_pos_t p;
    p = '0;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        if (sq[r][c] == code) begin
          p.row = pos_t'(r);
          p.col = pos_t'(c);
        end
      end
    end
    return p;
  endfunction

endpackage

>>> design/pfe_if.sv
// Channel interfaces of the Playfair encryptor: plaintext in, ciphertext out
// and the configuration write channel. Depends on pfe_pkg.
interface pfe_in_if;
  logic                      valid;
  logic                      ready;
  logic [pfe_pkg::BYTE_W-1:0] text_byte;
  logic                      message_end;

  modport source (output valid, output text_byte, output message_end, input ready);
  modport sink (input valid, input text_byte, input message_end, output ready);
endinterface

interface pfe_out_if;
  logic                       valid;
  logic                       ready;
  logic [pfe_pkg::ASCII_W-1:0] cipher_letter;
  logic                       run_last;
  logic                       message_done;

  modport source (output valid, output cipher_letter, output run_last,
                  output message_done, input ready);
  modport sink (input valid, input cipher_letter, input run_last,
                input message_done, output ready);
endinterface

interface pfe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pfe_pkg::CFG_IDX_W-1:0] index;
  logic [pfe_pkg::ROW_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/pfe_pairing.sv
// Input side of the Playfair encryptor: letter filtering, the held letter,
// and the job register that offers up to two pairs per item.
// Depends on pfe_pkg and pfe_if.
module pfe_pairing (
  input  logic                clk,
  input  logic                rst,
  pfe_in_if.sink              plain,
  output logic                pair_valid,
  output pfe_pkg::pair_req_t  pair_req,
  input  logic                pair_take
);
  import pfe_pkg::*;

  code_t held_letter, held_letter_next;
  logic  held_valid, held_valid_next;

  logic  job_valid;
  logic  job_phase;
  pair_t job_p0, job_p1;
  logic  job_p1_valid;
  logic  job_end;

  logic  is_letter;
  code_t code;
  logic  first_valid, pad_valid;
  pair_t first_pair, pad_pair;
  pair_t new_p0, new_p1;
  logic  new_p1_valid, new_any;
  logic  accept;

  always_comb begin
    is_letter = 1'b0;
    code = '0;
    if (plain.text_byte >= ASCII_LOWER_A && plain.text_byte <= ASCII_LOWER_Z) begin
      is_letter = 1'b1;
      code = code_t'(plain.text_byte - ASCII_LOWER_A);
    end else if (plain.text_byte >= ASCII_UPPER_A && plain.text_byte <= ASCII_UPPER_Z) begin
      is_letter = 1'b1;
      code = code_t'(plain.text_byte - ASCII_UPPER_A);
    end
    if (code == CODE_J) begin
      code = CODE_I;
    end

    held_letter_next = held_letter;
    held_valid_next = held_valid;
    first_valid = 1'b0;
    first_pair.first = held_letter;
    first_pair.second = code;
    if (is_letter) begin
      if (!held_valid) begin
        held_letter_next = code;
        held_valid_next = 1'b1;
      end else if (code == held_letter) begin
        // A doubled letter is split by X and stays held.
        first_valid = 1'b1;
        first_pair.second = CODE_X;
      end else begin
        first_valid = 1'b1;
        held_valid_next = 1'b0;
      end
    end

    pad_valid = plain.message_end && held_valid_next;
    pad_pair.first = held_letter_next;
    pad_pair.second = CODE_Z;
    if (plain.message_end) begin
      held_valid_next = 1'b0;
      held_letter_next = '0;
    end

    if (first_valid) begin
      new_p0 = first_pair;
      new_p1 = pad_pair;
      new_p1_valid = pad_valid;
    end else begin
      new_p0 = pad_pair;
      new_p1 = pad_pair;
      new_p1_valid = 1'b0;
    end
    new_any = first_valid || pad_valid;
  end

  assign pair_valid = job_valid;
  assign pair_req.pair = job_phase ? job_p1 : job_p0;
  assign pair_req.last = job_phase || !job_p1_valid;
  assign pair_req.msg_end = job_end;

  assign plain.ready = !job_valid || (pair_take && pair_req.last);
  assign accept = plain.valid && plain.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid <= 1'b0;
      job_valid <= 1'b0;
      job_phase <= 1'b0;
    end else begin
      if (accept) begin
        held_letter <= held_letter_next;
        held_valid <= held_valid_next;
        job_valid <= new_any;
        job_phase <= 1'b0;
      end else if (pair_take) begin
        if (pair_req.last) begin
          job_valid <= 1'b0;
        end else begin
          job_phase <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_p0 <= new_p0;
      job_p1 <= new_p1;
      job_p1_valid <= new_p1_valid;
      job_end <= plain.message_end;
    end
  end

endmodule

>>> design/pfe_cipher.sv
// Playfair substitution of one letter pair against the key square.
// Depends on pfe_pkg.
module pfe_cipher (
  input  pfe_pkg::square_t     square,
  input  pfe_pkg::pair_req_t   pair_req,
  output pfe_pkg::coded_pair_t coded
);
  import pfe_pkg::*;

  cell_pos_t pa, pb;

  assign pa = locate(square, pair_req.pair.first);
  assign pb = locate(square, pair_req.pair.second);

  always_comb begin
    coded.last = pair_req.last;
    coded.msg_end = pair_req.msg_end;
    if (pa.row == pb.row) begin
      // Same row, which also covers both letters in one cell.
      coded.first = square[pa.row][pos_inc(pa.col)];
      coded.second = square[pb.row][pos_inc(pb.col)];
    end else if (pa.col == pb.col) begin
      coded.first = square[pos_inc(pa.row)][pa.col];
      coded.second = square[pos_inc(pb.row)][pb.col];
    end else begin
      coded.first = square[pa.row][pb.col];
      coded.second = square[pb.row][pa.col];
    end
  end

endmodule

>>> design/pfe_emit.sv
// Result buffer of the Playfair encryptor: holds one encrypted pair and
// sends its two letters one transfer at a time. Depends on pfe_pkg and pfe_if.
module pfe_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  input  pfe_pkg::coded_pair_t coded,
  output logic                 pair_take,
  pfe_out_if.source            cipher
);
  import pfe_pkg::*;

  logic        buf_valid;
  logic        buf_second;
  coded_pair_t buf_pair;
  logic        pop;
  code_t       out_code;

  assign pop = buf_valid && buf_second && cipher.ready;
  assign pair_take = pair_valid && (!buf_valid || pop);

  assign out_code = buf_second ? buf_pair.second : buf_pair.first;
  assign cipher.valid = buf_valid;
  assign cipher.cipher_letter = ASCII_BASE + ASCII_W'(out_code);
  assign cipher.run_last = buf_second && buf_pair.last;
  assign cipher.message_done = buf_second && buf_pair.last && buf_pair.msg_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_second <= 1'b0;
    end else begin
      if (pair_take) begin
        buf_valid <= 1'b1;
        buf_second <= 1'b0;
      end else if (pop) begin
        buf_valid <= 1'b0;
        buf_second <= 1'b0;
      end else if (buf_valid && cipher.ready) begin
        buf_second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_take) begin
      buf_pair <= coded;
    end
  end

endmodule

>>> design/playfair_encrypt_stream.sv
// Streaming Playfair encryptor. Each pair passes the job register and then the
// result buffer before its first letter is offered. The result port sends one
// letter per cycle while cipher.ready is high, two letters per ciphertext pair;
// an item that also flushes a Z-padded pair yields two pairs. Items that only
// fill the held letter yield no pair. Reset (synchronous, rst high) restores
// the default square ABCDE/FGHIK/LMNOP/QRSTU/VWXYZ and clears the held letter.
module playfair_encrypt_stream (
  input  logic   clk,
  input  logic   rst,
  pfe_in_if.sink plain,
  pfe_out_if.source cipher,
  pfe_cfg_if.sink cfg
);
  import pfe_pkg::*;

  // The key square lives in five row registers, one letter code per column.
  square_t square;

  logic        pair_valid;
  logic        pair_take;
  pair_req_t   pair_req;
  coded_pair_t coded;

  // Configuration writes are always taken; an index past the last row is
  // ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      square <= SQUARE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW0: square[0] <= row_t'(cfg.data);
        REG_ROW1: square[1] <= row_t'(cfg.data);
        REG_ROW2: square[2] <= row_t'(cfg.data);
        REG_ROW3: square[3] <= row_t'(cfg.data);
        REG_ROW4: square[4] <= row_t'(cfg.data);
        default: begin
        end
      endcase
    end
  end

  // Front end: drops non-letters, folds case and J, keeps the held letter,
  // and registers the pairs, at most two, that each plaintext transfer yields.
  pfe_pairing u_pairing (
    .clk        (clk),
    .rst        (rst),
    .plain      (plain),
    .pair_valid (pair_valid),
    .pair_req   (pair_req),
    .pair_take  (pair_take)
  );

  // The square lookup sits between the job register and the result buffer.
  pfe_cipher u_cipher (
    .square   (square),
    .pair_req (pair_req),
    .coded    (coded)
  );

  // The result buffer takes a new pair as its last letter leaves, so the
  // front end is free to take the next item while a result still waits.
  pfe_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .coded      (coded),
    .pair_take  (pair_take),
    .cipher     (cipher)
  );

endmodule
